FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/gctt_pkg.sv
// shared types, register indexes and character tables of the console text transcoder
// no dependencies
package gctt_pkg;

	localparam int TABLE_SIZE = 96;
	localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

	localparam logic [7:0] LINE_FEED = 8'h0A;
	localparam logic [7:0] ASCII_UNKNOWN = 8'h3F;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [7:0] NL_CODE_A = 8'o214;
	localparam logic [7:0] NL_CODE_B = 8'o175;

	// configuration register indexes
	localparam logic REG_UNICODE_MODE = 1'b0;
	localparam logic REG_TERMINATE_LINES = 1'b1;

	// bytes of one input code, byte 0 sent first, last is the index of the final byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0] last;
	} run_t;

	localparam logic [15:0] UNI_TABLE [TABLE_SIZE] = '{
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h002B, 16'h002D, 16'h002F, 16'h002C, 16'h002E, 16'h0020,
		16'h23E8, 16'h2191, 16'h0028, 16'h0029, 16'h00D7, 16'h003D, 16'h003B, 16'h005B,
		16'h005D, 16'h002A, 16'h2018, 16'h2019, 16'h2260, 16'h003C, 16'h003E, 16'h003A,
		16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
		16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
		16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
		16'h0428, 16'h0429, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F, 16'h0044,
		16'h0046, 16'h0047, 16'h0049, 16'h004A, 16'h004C, 16'h004E, 16'h0051, 16'h0052,
		16'h0053, 16'h0055, 16'h0056, 16'h0057, 16'h005A, 16'h203E, 16'h2A7D, 16'h2A7E,
		16'h2228, 16'h2227, 16'h2283, 16'h00AC, 16'h00F7, 16'h2261, 16'h0025, 16'h25C7,
		16'h007C, 16'h2015, 16'h005F, 16'h0021, 16'h0022, 16'h042A, 16'h00B0, 16'h2032
	};

	localparam logic [7:0] ASC_TABLE [TABLE_SIZE] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h2B, 8'h2D, 8'h2F, 8'h2C, 8'h2E, 8'h20,
		8'h3F, 8'h40, 8'h28, 8'h29, 8'h3F, 8'h3D, 8'h3B, 8'h5B,
		8'h5D, 8'h2A, 8'h60, 8'h27, 8'h23, 8'h3C, 8'h3E, 8'h3A,
		8'h41, 8'h3F, 8'h42, 8'h3F, 8'h3F, 8'h45, 8'h3F, 8'h3F,
		8'h3F, 8'h3F, 8'h4B, 8'h3F, 8'h4D, 8'h48, 8'h4F, 8'h3F,
		8'h50, 8'h43, 8'h54, 8'h59, 8'h3F, 8'h58, 8'h3F, 8'h3F,
		8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h44,
		8'h46, 8'h47, 8'h49, 8'h4A, 8'h4C, 8'h4E, 8'h51, 8'h52,
		8'h53, 8'h55, 8'h56, 8'h57, 8'h5A, 8'h5E, 8'h3F, 8'h3F,
		8'h3F, 8'h26, 8'h3F, 8'h7E, 8'h3F, 8'h3F, 8'h25, 8'h3F,
		8'h7C, 8'h3F, 8'h5F, 8'h21, 8'h22, 8'h3F, 8'h3F, 8'h3F
	};

endpackage

FILE: hw/rtl/gost_console_text_transcoder.sv
// console code to byte stream transcoder, top level
// path: an accepted code waits in the input register until the serializer is free or sends
// its last byte, then it is loaded into the serializer, which offers its first byte
// throughput: one byte per cycle on the output while out_stall is low; a code makes 1 to 4
// bytes, sent by the byte serializer; input register takes a code a cycle unless in_stall
// reset: arst_n clears all valid flags and both configuration registers to zero
// depends on gctt_pkg, gctt_encoder and assert_macros.svh
`include "assert_macros.svh"
module gost_console_text_transcoder import gctt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] gost_code,
	input  logic       end_of_record,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic unicode_mode_q;
	logic terminate_lines_q;

	run_t enc_run;
	run_t run_s1;
	logic valid_s1;
	run_t cur_q;
	logic cur_valid_q;
	logic [1:0] idx_q;

	logic in_fire;
	logic out_fire;
	logic cur_done;
	logic cur_free;
	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unicode_mode_q <= 1'b0;
			terminate_lines_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UNICODE_MODE:    unicode_mode_q <= cfg_wdata;
				REG_TERMINATE_LINES: terminate_lines_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gctt_encoder u_encoder (
		.gost_code       (gost_code),
		.end_of_record   (end_of_record),
		.unicode_mode    (unicode_mode_q),
		.terminate_lines (terminate_lines_q),
		.run             (enc_run)
	);

	assign out_fire = cur_valid_q && !out_stall;
	assign cur_done = out_fire && (idx_q == cur_q.last);
	assign cur_free = !cur_valid_q || cur_done;
	assign advance = valid_s1 && cur_free;
	assign in_stall = valid_s1 && !cur_free;
	assign in_fire = in_valid && !in_stall;

	// input register, holds one encoded transaction while the serializer is busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			run_s1 <= enc_run;
		end
	end

	// byte serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (advance) begin
			cur_valid_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cur_q <= run_s1;
		end
	end

	assign out_valid = cur_valid_q;
	assign out_byte = cur_q.bytes[idx_q];
	assign last_of_run = (idx_q == cur_q.last);

	`ASSERT_IMPL(a_idx_in_run, cur_valid_q, idx_q <= cur_q.last)
	`ASSERT_IMPL(a_stall_only_full, in_stall, valid_s1 && cur_valid_q)
	`ASSERT_NEXT(a_advance_starts, advance, cur_valid_q && idx_q == 2'd0)
	`ASSERT_NEXT(a_s1_holds, valid_s1 && !cur_free, valid_s1 && $stable(run_s1))

endmodule

FILE: hw/rtl/gctt_encoder.sv
// combinational encoder: one console code to its run of output bytes
// depends on gctt_pkg
module gctt_encoder import gctt_pkg::*; (
	input  logic [7:0] gost_code,
	input  logic       end_of_record,
	input  logic       unicode_mode,
	input  logic       terminate_lines,
	output run_t       run
);

	logic                   is_newline;
	logic                   in_table;
	logic [TABLE_IDX_W-1:0] tidx;
	logic [15:0]            cp;
	logic [3:0][7:0]        base;
	logic [1:0]             base_last;
	logic                   add_lf;

	assign is_newline = (gost_code == NL_CODE_A) || (gost_code == NL_CODE_B);
	assign in_table = gost_code < 8'(TABLE_SIZE);
	assign tidx = gost_code[TABLE_IDX_W-1:0];
	assign cp = in_table ? UNI_TABLE[tidx] : REPLACEMENT;
	assign add_lf = end_of_record && terminate_lines && !is_newline;

	always_comb begin
		base = '0;
		base_last = 2'd0;
		if (is_newline) begin
			base[0] = LINE_FEED;
		end else if (unicode_mode) begin
			if (cp <= 16'h007F) begin
				base[0] = cp[7:0];
			end else if (cp <= 16'h07FF) begin
				base[0] = {3'b110, cp[10:6]};
				base[1] = {2'b10, cp[5:0]};
				base_last = 2'd1;
			end else begin
				base[0] = {4'b1110, cp[15:12]};
				base[1] = {2'b10, cp[11:6]};
				base[2] = {2'b10, cp[5:0]};
				base_last = 2'd2;
			end
		end else begin
			base[0] = in_table ? ASC_TABLE[tidx] : ASCII_UNKNOWN;
		end
	end

	// record-end line feed goes right after the character bytes
	always_comb begin
		run.bytes = base;
		run.last = base_last;
		if (add_lf) begin
			run.bytes[base_last + 2'd1] = LINE_FEED;
			run.last = base_last + 2'd1;
		end
	end

endmodule

FILE: tb/sv/tb_gost_console_text_transcoder.sv
`timescale 1ns / 100ps
// self-checking testbench for gost_console_text_transcoder: directed and random console codes
// checked byte by byte against an in-bench encoder; depends on gctt_pkg and the dut rtl
module tb_gost_console_text_transcoder;
	import gctt_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int GLYPH_COUNT = 96;

	localparam logic [7:0] NL_CODE_OCT214 = 8'o214;
	localparam logic [7:0] NL_CODE_OCT175 = 8'o175;
	localparam logic [7:0] FIRST_UNMAPPED = 8'o140;
	localparam logic [7:0] LAST_MAPPED = 8'o137;
	localparam logic [7:0] LF_BYTE = 8'h0A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;
	localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;

	// code point of each console code
	localparam logic [15:0] glyph_point [GLYPH_COUNT] = '{
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h002B, 16'h002D, 16'h002F, 16'h002C, 16'h002E, 16'h0020,
		16'h23E8, 16'h2191, 16'h0028, 16'h0029, 16'h00D7, 16'h003D, 16'h003B, 16'h005B,
		16'h005D, 16'h002A, 16'h2018, 16'h2019, 16'h2260, 16'h003C, 16'h003E, 16'h003A,
		16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
		16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
		16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
		16'h0428, 16'h0429, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F, 16'h0044,
		16'h0046, 16'h0047, 16'h0049, 16'h004A, 16'h004C, 16'h004E, 16'h0051, 16'h0052,
		16'h0053, 16'h0055, 16'h0056, 16'h0057, 16'h005A, 16'h203E, 16'h2A7D, 16'h2A7E,
		16'h2228, 16'h2227, 16'h2283, 16'h00AC, 16'h00F7, 16'h2261, 16'h0025, 16'h25C7,
		16'h007C, 16'h2015, 16'h005F, 16'h0021, 16'h0022, 16'h042A, 16'h00B0, 16'h2032
	};

	// closest ascii byte of each console code, '?' where there is none
	localparam logic [7:0] ascii_glyph [GLYPH_COUNT] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h2B, 8'h2D, 8'h2F, 8'h2C, 8'h2E, 8'h20,
		8'h3F, 8'h40, 8'h28, 8'h29, 8'h3F, 8'h3D, 8'h3B, 8'h5B,
		8'h5D, 8'h2A, 8'h60, 8'h27, 8'h23, 8'h3C, 8'h3E, 8'h3A,
		8'h41, 8'h3F, 8'h42, 8'h3F, 8'h3F, 8'h45, 8'h3F, 8'h3F,
		8'h3F, 8'h3F, 8'h4B, 8'h3F, 8'h4D, 8'h48, 8'h4F, 8'h3F,
		8'h50, 8'h43, 8'h54, 8'h59, 8'h3F, 8'h58, 8'h3F, 8'h3F,
		8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h44,
		8'h46, 8'h47, 8'h49, 8'h4A, 8'h4C, 8'h4E, 8'h51, 8'h52,
		8'h53, 8'h55, 8'h56, 8'h57, 8'h5A, 8'h5E, 8'h3F, 8'h3F,
		8'h3F, 8'h26, 8'h3F, 8'h7E, 8'h3F, 8'h3F, 8'h25, 8'h3F,
		8'h7C, 8'h3F, 8'h5F, 8'h21, 8'h22, 8'h3F, 8'h3F, 8'h3F
	};

	typedef enum int {RX_FREE, RX_COIN, RX_BUSY, RX_PERIODIC} rx_mode_e;

	typedef struct {
		logic [7:0] data;
		logic last;
	} out_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_addr;
	logic cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [7:0] gost_code;
	logic end_of_record;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic last_of_run;

	// shadow copy of the configuration registers
	logic uni_on;
	logic term_on;

	out_beat_t pending_bytes [$];
	int mismatch_count = 0;

	gost_console_text_transcoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gost_code(gost_code),
		.end_of_record(end_of_record),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_gost_console_text_transcoder: errors");
		$finish;
	end

	// bytes one console code turns into under the current settings
	function automatic void encode_code(input logic [7:0] code, input logic eor);
		logic [15:0] cp;
		logic nl;
		logic [7:0] run_bytes [4];
		int n;
		out_beat_t beat;
		n = 0;
		nl = (code == NL_CODE_OCT214) || (code == NL_CODE_OCT175);
		if (nl) begin
			run_bytes[n] = LF_BYTE;
			n++;
		end else if (uni_on) begin
			cp = (code < GLYPH_COUNT) ? glyph_point[code] : REPLACEMENT_CP;
			if (cp <= 16'h007F) begin
				run_bytes[n] = cp[7:0];
				n++;
			end else if (cp <= 16'h07FF) begin
				run_bytes[n] = 8'hC0 | {3'b000, cp[10:6]};
				n++;
				run_bytes[n] = 8'h80 | {2'b00, cp[5:0]};
				n++;
			end else begin
				run_bytes[n] = 8'hE0 | {4'h0, cp[15:12]};
				n++;
				run_bytes[n] = 8'h80 | {2'b00, cp[11:6]};
				n++;
				run_bytes[n] = 8'h80 | {2'b00, cp[5:0]};
				n++;
			end
		end else begin
			run_bytes[n] = (code < GLYPH_COUNT) ? ascii_glyph[code] : QMARK_BYTE;
			n++;
		end
		if (eor && term_on && !nl) begin
			run_bytes[n] = LF_BYTE;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			beat.data = run_bytes[i];
			beat.last = (i == n - 1);
			pending_bytes.insert(pending_bytes.size(), beat);
		end
	endfunction

	// one input transaction; leaves in_valid high so bursts stay back to back
	task automatic send_code(input logic [7:0] code, input logic eor);
		in_valid <= 1'b1;
		gost_code <= code;
		end_of_record <= eor;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_code(code, eor);
	endtask

	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_mode(input logic uni, input logic term);
		cfg_we <= 1'b1;
		cfg_addr <= REG_UNICODE_MODE;
		cfg_wdata <= uni;
		@(posedge clk);
		cfg_addr <= REG_TERMINATE_LINES;
		cfg_wdata <= term;
		@(posedge clk);
		cfg_we <= 1'b0;
		uni_on = uni;
		term_on = term;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return ($urandom_range(0, 1) == 1) ? NL_CODE_OCT214 : NL_CODE_OCT175;
		else if (r < 5)
			return 8'($urandom_range(FIRST_UNMAPPED, 255));
		else if (r == 5)
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return LAST_MAPPED;
				default: return FIRST_UNMAPPED;
			endcase
		else
			return 8'($urandom_range(0, LAST_MAPPED));
	endfunction

	// random bursts and gaps; halfway through the sender holds off until all bytes are out
	task automatic run_random(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_code(pick_code(), $urandom_range(0, 3) == 0);
				sent++;
				if (sent == count / 2)
					wait_drained(0);
			end
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		wait_drained(SETTLE_CYCLES);
	endtask

	task automatic test_reset_defaults();
		send_code(8'h00, 1'b0);
		send_code(8'hFF, 1'b1);
		send_code(LAST_MAPPED, 1'b0);
		send_code(FIRST_UNMAPPED, 1'b1);
		send_code(NL_CODE_OCT214, 1'b0);
		send_code(8'h10, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	task automatic test_unicode_runs();
		set_mode(1'b1, 1'b1);
		send_code(8'h0F, 1'b0);
		send_code(8'h14, 1'b0);
		send_code(8'h10, 1'b0);
		send_code(FIRST_UNMAPPED, 1'b1);
		send_code(8'h4F, 1'b1);
		send_code(NL_CODE_OCT214, 1'b1);
		send_code(NL_CODE_OCT175, 1'b1);
		send_code(LAST_MAPPED, 1'b0);
		send_code(8'hFF, 1'b1);
		wait_drained(SETTLE_CYCLES);
	endtask

	task automatic test_record_end_ascii();
		set_mode(1'b0, 1'b1);
		send_code(8'h21, 1'b1);
		send_code(NL_CODE_OCT175, 1'b1);
		send_code(8'hC3, 1'b1);
		send_code(8'h3F, 1'b0);
		send_code(NL_CODE_OCT214, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	task automatic test_random_settings();
		set_mode(1'b0, 1'b0);
		run_random(90);
		set_mode(1'b1, 1'b0);
		run_random(90);
		set_mode(1'b0, 1'b1);
		run_random(95);
		set_mode(1'b1, 1'b1);
		run_random(95);
	endtask

	// output stall pattern, switching to a randomly chosen style when the current one runs out
	initial begin : rx_pattern
		rx_mode_e mode;
		int left;
		int tick;
		out_stall <= 1'b0;
		mode = RX_FREE;
		left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(8, 80);
			end
			left--;
			tick++;
			case (mode)
				RX_FREE: out_stall <= 1'b0;
				RX_COIN: out_stall <= ($urandom_range(0, 1) == 1);
				RX_BUSY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((tick % 5) < 2);
			endcase
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected byte: expected none, actual %02h last %0b",
					$time, out_byte, last_of_run);
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.data) begin
					mismatch_count++;
					$display("%0t out_byte: expected %02h, actual %02h",
						$time, want.data, out_byte);
				end
				if (last_of_run !== want.last) begin
					mismatch_count++;
					$display("%0t last_of_run: expected %0b, actual %0b",
						$time, want.last, last_of_run);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_UNICODE_MODE;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		gost_code <= 8'h00;
		end_of_record <= 1'b0;
		uni_on = 1'b0;
		term_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_unicode_runs();
		test_record_end_ascii();
		test_random_settings();

		wait_drained(SETTLE_CYCLES * 4);
		if (pending_bytes.size() != 0) begin
			mismatch_count++;
			$display("%0t bytes never sent: expected 0, actual %0d",
				$time, pending_bytes.size());
		end
		if (mismatch_count == 0)
			$display("tb_gost_console_text_transcoder: clean");
		else
			$display("tb_gost_console_text_transcoder: errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gctt_pkg.sv
hw/rtl/gctt_encoder.sv
hw/rtl/gost_console_text_transcoder.sv
tb/sv/tb_gost_console_text_transcoder.sv
